// ===== rtl/nsrs_pkg.sv =====
// nsrs_pkg: shared constants and types for the nearest-seek request scheduler
// field widths, opcodes, status codes and the slot memory word layout
// no dependencies
package nsrs_pkg;

    localparam int unsigned POS_W    = 48;
    localparam int unsigned LEN_W    = 16;
    localparam int unsigned TAG_W    = 16;
    localparam int unsigned AGE_W    = 16;
    localparam int unsigned STATUS_W = 2;

    localparam logic OP_INSERT   = 1'b0;
    localparam logic OP_DISPATCH = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_INSERTED   = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL       = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_DISPATCHED = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY      = 2'd3;

    typedef struct packed {
        logic             valid;
        logic             is_lower;
        logic [POS_W-1:0] position;
        logic [LEN_W-1:0] length;
        logic [TAG_W-1:0] tag;
        logic [AGE_W-1:0] age;
    } slot_t;

endpackage

// ===== rtl/nsrs_if.sv =====
// nsrs_req_if / nsrs_rsp_if: valid/ready channels of the request scheduler
// one word per handshake; widths come from nsrs_pkg
interface nsrs_req_if;
    logic                       valid;
    logic                       ready;
    logic                       opcode;
    logic [nsrs_pkg::TAG_W-1:0] request_tag;
    logic [nsrs_pkg::POS_W-1:0] request_position;
    logic [nsrs_pkg::LEN_W-1:0] request_length;

    modport source (output valid, opcode, request_tag, request_position, request_length,
                    input ready);
    modport sink   (input valid, opcode, request_tag, request_position, request_length,
                    output ready);
endinterface

interface nsrs_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [nsrs_pkg::STATUS_W-1:0] status;
    logic [nsrs_pkg::TAG_W-1:0]    out_tag;
    logic [nsrs_pkg::POS_W-1:0]    out_position;
    logic [nsrs_pkg::LEN_W-1:0]    out_length;

    modport source (output valid, status, out_tag, out_position, out_length,
                    input ready);
    modport sink   (input valid, status, out_tag, out_position, out_length,
                    output ready);
endinterface

// ===== rtl/nearest_seek_request_scheduler.sv =====
// nearest_seek_request_scheduler: greedy nearest-seek disk request queue
// uses nsrs_pkg, nsrs_req_if, nsrs_rsp_if and nsrs_ram
//
// Every request word (insert or dispatch) returns exactly one response word. The
// queue lives in a QUEUE_DEPTH-entry slot memory that is swept one entry per cycle:
// an insert looks for the lowest free slot, a dispatch finds the nearest higher and
// nearest lower request, then the chosen slot is written back. Each word sweeps
// the whole slot memory through its single read port, and the next word is not
// accepted until the previous one has finished. After reset the block clears
// every entry of the slot memory before it accepts a word. A
// finished response waits in an output register, so the next word can be accepted
// while the previous response is still unclaimed.
module nearest_seek_request_scheduler #(
    parameter int unsigned QUEUE_DEPTH = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    nsrs_req_if.sink      req,
    nsrs_rsp_if.source    rsp
);

    localparam int unsigned AW = $clog2(QUEUE_DEPTH);
    localparam logic [AW:0]   DEPTH_CNT = (AW+1)'(QUEUE_DEPTH);
    localparam logic [AW-1:0] LAST_IDX  = AW'(QUEUE_DEPTH - 1);
    localparam int unsigned POS_W = nsrs_pkg::POS_W;
    localparam int unsigned LEN_W = nsrs_pkg::LEN_W;
    localparam int unsigned TAG_W = nsrs_pkg::TAG_W;
    localparam int unsigned AGE_W = nsrs_pkg::AGE_W;
    localparam int unsigned SW    = nsrs_pkg::STATUS_W;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_EVAL,
        ST_PICK,
        ST_FINISH
    } state_t;

    // control
    state_t            state_reg, state_next;
    logic [AW:0]       cnt_reg, cnt_next;
    logic              rvalid_reg, rvalid_next;
    logic [AW-1:0]     ridx_reg, ridx_next;
    logic              out_valid_reg, out_valid_next;
    logic [AGE_W-1:0]  arr_reg, arr_next;
    logic [POS_W-1:0]  head_reg, head_next;
    logic              free_found_reg, free_found_next;
    logic              hi_found_reg, hi_found_next;
    logic              lo_found_reg, lo_found_next;

    // payload
    logic              op_reg, op_next;
    logic [TAG_W-1:0]  tag_reg, tag_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [AW-1:0]     free_idx_reg, free_idx_next;
    logic [POS_W-1:0]  hi_pos_reg, hi_pos_next;
    logic [LEN_W-1:0]  hi_len_reg, hi_len_next;
    logic [TAG_W-1:0]  hi_tag_reg, hi_tag_next;
    logic [AGE_W-1:0]  hi_wait_reg, hi_wait_next;
    logic [AW-1:0]     hi_idx_reg, hi_idx_next;
    logic [POS_W-1:0]  lo_pos_reg, lo_pos_next;
    logic [LEN_W-1:0]  lo_len_reg, lo_len_next;
    logic [TAG_W-1:0]  lo_tag_reg, lo_tag_next;
    logic [AGE_W-1:0]  lo_wait_reg, lo_wait_next;
    logic [AW-1:0]     lo_idx_reg, lo_idx_next;
    logic signed [POS_W+1:0] up_reg, up_next;
    logic signed [POS_W+1:0] down_reg, down_next;
    logic [SW-1:0]     status_reg, status_next;
    logic [AW-1:0]     sel_idx_reg, sel_idx_next;
    logic [POS_W-1:0]  sel_pos_reg, sel_pos_next;
    logic [LEN_W-1:0]  sel_len_reg, sel_len_next;
    logic [TAG_W-1:0]  sel_tag_reg, sel_tag_next;
    logic [SW-1:0]     out_status_reg, out_status_next;
    logic [TAG_W-1:0]  out_tag_reg, out_tag_next;
    logic [POS_W-1:0]  out_pos_reg, out_pos_next;
    logic [LEN_W-1:0]  out_len_reg, out_len_next;

    // slot memory
    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    nsrs_pkg::slot_t       mem_wdata;
    nsrs_pkg::slot_t       rd_slot;
    logic [$bits(nsrs_pkg::slot_t)-1:0] mem_rdata;

    logic                  accept;
    logic [AGE_W-1:0]      rd_wait;
    logic                  pick_lo;
    logic [POS_W:0]        head_sum;
    logic                  new_lower;

    nsrs_ram #(
        .WIDTH ($bits(nsrs_pkg::slot_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_slot_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (cnt_reg[AW-1:0]),
        .rdata (mem_rdata)
    );

    assign rd_slot   = nsrs_pkg::slot_t'(mem_rdata);
    assign accept    = req.valid && req.ready;
    assign rd_wait   = arr_reg - rd_slot.age;
    assign pick_lo   = lo_found_reg && (!hi_found_reg || (up_reg > down_reg));
    assign head_sum  = {1'b0, sel_pos_reg} + (POS_W+1)'(sel_len_reg);
    assign new_lower = (head_reg != '0) && (head_reg > pos_reg);

    assign req.ready        = (state_reg == ST_IDLE);
    assign rsp.valid        = out_valid_reg;
    assign rsp.status       = out_status_reg;
    assign rsp.out_tag      = out_tag_reg;
    assign rsp.out_position = out_pos_reg;
    assign rsp.out_length   = out_len_reg;

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        rvalid_next     = rvalid_reg;
        ridx_next       = ridx_reg;
        out_valid_next  = out_valid_reg;
        arr_next        = arr_reg;
        head_next       = head_reg;
        free_found_next = free_found_reg;
        hi_found_next   = hi_found_reg;
        lo_found_next   = lo_found_reg;
        op_next         = op_reg;
        tag_next        = tag_reg;
        pos_next        = pos_reg;
        len_next        = len_reg;
        free_idx_next   = free_idx_reg;
        hi_pos_next     = hi_pos_reg;
        hi_len_next     = hi_len_reg;
        hi_tag_next     = hi_tag_reg;
        hi_wait_next    = hi_wait_reg;
        hi_idx_next     = hi_idx_reg;
        lo_pos_next     = lo_pos_reg;
        lo_len_next     = lo_len_reg;
        lo_tag_next     = lo_tag_reg;
        lo_wait_next    = lo_wait_reg;
        lo_idx_next     = lo_idx_reg;
        up_next         = up_reg;
        down_next       = down_reg;
        status_next     = status_reg;
        sel_idx_next    = sel_idx_reg;
        sel_pos_next    = sel_pos_reg;
        sel_len_next    = sel_len_reg;
        sel_tag_next    = sel_tag_reg;
        out_status_next = out_status_reg;
        out_tag_next    = out_tag_reg;
        out_pos_next    = out_pos_reg;
        out_len_next    = out_len_reg;
        mem_we          = 1'b0;
        mem_waddr       = cnt_reg[AW-1:0];
        mem_wdata       = '0;

        if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                mem_we = 1'b1;
                if (cnt_reg[AW-1:0] == LAST_IDX)
                begin
                    cnt_next   = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    op_next         = req.opcode;
                    tag_next        = req.request_tag;
                    pos_next        = req.request_position;
                    len_next        = req.request_length;
                    cnt_next        = '0;
                    rvalid_next     = 1'b0;
                    free_found_next = 1'b0;
                    hi_found_next   = 1'b0;
                    lo_found_next   = 1'b0;
                    state_next      = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                rvalid_next = (cnt_reg != DEPTH_CNT);
                ridx_next   = cnt_reg[AW-1:0];
                if (cnt_reg != DEPTH_CNT)
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
                if (rvalid_reg)
                begin
                    if (op_reg == nsrs_pkg::OP_INSERT)
                    begin
                        if (!rd_slot.valid && !free_found_reg)
                        begin
                            free_found_next = 1'b1;
                            free_idx_next   = ridx_reg;
                        end
                    end
                    else if (rd_slot.valid)
                    begin
                        if (rd_slot.is_lower)
                        begin
                            // nearest below: highest sector, oldest on a tie
                            if (!lo_found_reg || (rd_slot.position > lo_pos_reg) ||
                                ((rd_slot.position == lo_pos_reg) && (rd_wait > lo_wait_reg)))
                            begin
                                lo_found_next = 1'b1;
                                lo_pos_next   = rd_slot.position;
                                lo_len_next   = rd_slot.length;
                                lo_tag_next   = rd_slot.tag;
                                lo_wait_next  = rd_wait;
                                lo_idx_next   = ridx_reg;
                            end
                        end
                        else
                        begin
                            // nearest above: lowest sector, oldest on a tie
                            if (!hi_found_reg || (rd_slot.position < hi_pos_reg) ||
                                ((rd_slot.position == hi_pos_reg) && (rd_wait > hi_wait_reg)))
                            begin
                                hi_found_next = 1'b1;
                                hi_pos_next   = rd_slot.position;
                                hi_len_next   = rd_slot.length;
                                hi_tag_next   = rd_slot.tag;
                                hi_wait_next  = rd_wait;
                                hi_idx_next   = ridx_reg;
                            end
                        end
                    end
                    if (ridx_reg == LAST_IDX)
                    begin
                        state_next = ST_EVAL;
                    end
                end
            end
            ST_EVAL:
            begin
                up_next    = $signed({2'b00, hi_pos_reg}) - $signed({2'b00, head_reg});
                down_next  = $signed({2'b00, head_reg}) - $signed({2'b00, lo_pos_reg});
                state_next = ST_PICK;
            end
            ST_PICK:
            begin
                if (op_reg == nsrs_pkg::OP_INSERT)
                begin
                    status_next  = free_found_reg ? nsrs_pkg::STATUS_INSERTED
                                                  : nsrs_pkg::STATUS_FULL;
                    sel_idx_next = free_idx_reg;
                end
                else
                begin
                    status_next  = (hi_found_reg || lo_found_reg) ? nsrs_pkg::STATUS_DISPATCHED
                                                                  : nsrs_pkg::STATUS_EMPTY;
                    sel_idx_next = pick_lo ? lo_idx_reg : hi_idx_reg;
                    sel_pos_next = pick_lo ? lo_pos_reg : hi_pos_reg;
                    sel_len_next = pick_lo ? lo_len_reg : hi_len_reg;
                    sel_tag_next = pick_lo ? lo_tag_reg : hi_tag_reg;
                end
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                mem_waddr = sel_idx_reg;
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = status_reg;
                    if (status_reg == nsrs_pkg::STATUS_DISPATCHED)
                    begin
                        out_tag_next = sel_tag_reg;
                        out_pos_next = sel_pos_reg;
                        out_len_next = sel_len_reg;
                        mem_we       = 1'b1;
                        head_next    = head_sum[POS_W] ? '1 : head_sum[POS_W-1:0];
                    end
                    else
                    begin
                        out_tag_next = '0;
                        out_pos_next = '0;
                        out_len_next = '0;
                    end
                    if (status_reg == nsrs_pkg::STATUS_INSERTED)
                    begin
                        mem_we             = 1'b1;
                        mem_wdata.valid    = 1'b1;
                        mem_wdata.is_lower = new_lower;
                        mem_wdata.position = pos_reg;
                        mem_wdata.length   = len_reg;
                        mem_wdata.tag      = tag_reg;
                        mem_wdata.age      = arr_reg;
                        arr_next           = arr_reg + 1'b1;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                cnt_next   = '0;
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            cnt_reg        <= '0;
            rvalid_reg     <= 1'b0;
            ridx_reg       <= '0;
            out_valid_reg  <= 1'b0;
            arr_reg        <= '0;
            head_reg       <= '0;
            free_found_reg <= 1'b0;
            hi_found_reg   <= 1'b0;
            lo_found_reg   <= 1'b0;
            op_reg         <= 1'b0;
            tag_reg        <= '0;
            pos_reg        <= '0;
            len_reg        <= '0;
            free_idx_reg   <= '0;
            hi_pos_reg     <= '0;
            hi_len_reg     <= '0;
            hi_tag_reg     <= '0;
            hi_wait_reg    <= '0;
            hi_idx_reg     <= '0;
            lo_pos_reg     <= '0;
            lo_len_reg     <= '0;
            lo_tag_reg     <= '0;
            lo_wait_reg    <= '0;
            lo_idx_reg     <= '0;
            up_reg         <= '0;
            down_reg       <= '0;
            status_reg     <= '0;
            sel_idx_reg    <= '0;
            sel_pos_reg    <= '0;
            sel_len_reg    <= '0;
            sel_tag_reg    <= '0;
            out_status_reg <= '0;
            out_tag_reg    <= '0;
            out_pos_reg    <= '0;
            out_len_reg    <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            rvalid_reg     <= rvalid_next;
            ridx_reg       <= ridx_next;
            out_valid_reg  <= out_valid_next;
            arr_reg        <= arr_next;
            head_reg       <= head_next;
            free_found_reg <= free_found_next;
            hi_found_reg   <= hi_found_next;
            lo_found_reg   <= lo_found_next;
            op_reg         <= op_next;
            tag_reg        <= tag_next;
            pos_reg        <= pos_next;
            len_reg        <= len_next;
            free_idx_reg   <= free_idx_next;
            hi_pos_reg     <= hi_pos_next;
            hi_len_reg     <= hi_len_next;
            hi_tag_reg     <= hi_tag_next;
            hi_wait_reg    <= hi_wait_next;
            hi_idx_reg     <= hi_idx_next;
            lo_pos_reg     <= lo_pos_next;
            lo_len_reg     <= lo_len_next;
            lo_tag_reg     <= lo_tag_next;
            lo_wait_reg    <= lo_wait_next;
            lo_idx_reg     <= lo_idx_next;
            up_reg         <= up_next;
            down_reg       <= down_next;
            status_reg     <= status_next;
            sel_idx_reg    <= sel_idx_next;
            sel_pos_reg    <= sel_pos_next;
            sel_len_reg    <= sel_len_next;
            sel_tag_reg    <= sel_tag_next;
            out_status_reg <= out_status_next;
            out_tag_reg    <= out_tag_next;
            out_pos_reg    <= out_pos_next;
            out_len_reg    <= out_len_next;
        end
    end

`ifndef ASSERT_OFF
    a_non_dispatch_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && (rsp.status != nsrs_pkg::STATUS_DISPATCHED)) |->
        ((rsp.out_tag == '0) && (rsp.out_position == '0) && (rsp.out_length == '0)))
        else $error("non-dispatch response carries a nonzero payload");

    a_mem_write_phase: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> ((state_reg == ST_CLEAR) || (state_reg == ST_FINISH)))
        else $error("slot memory written outside clear or write back");

    a_head_move: assert property (@(posedge clk) disable iff (!rst_n)
        (head_reg != $past(head_reg)) |->
        (($past(state_reg) == ST_FINISH) &&
         ($past(status_reg) == nsrs_pkg::STATUS_DISPATCHED)))
        else $error("head moved without a dispatch");

    a_accept_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> (state_reg == ST_SCAN))
        else $error("accepted word did not start a slot sweep");
`endif

endmodule

// ===== rtl/nsrs_ram.sv =====
// nsrs_ram: generic single-write, single-read RAM with registered read data
// no dependencies
module nsrs_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== verif/nearest_seek_request_scheduler_tb.sv =====
`timescale 1ns / 100ps
// nearest_seek_request_scheduler_tb: checks every response word of the seek scheduler
// against a built-in queue predictor, under random idling on both channels
// depends on nsrs_pkg, nsrs_req_if, nsrs_rsp_if and nearest_seek_request_scheduler
module nearest_seek_request_scheduler_tb;

    localparam int unsigned POS_W    = nsrs_pkg::POS_W;
    localparam int unsigned LEN_W    = nsrs_pkg::LEN_W;
    localparam int unsigned TAG_W    = nsrs_pkg::TAG_W;
    localparam int unsigned AGE_W    = nsrs_pkg::AGE_W;
    localparam int unsigned STATUS_W = nsrs_pkg::STATUS_W;

    localparam int DEPTH = 32;
    localparam int RANDOM_WORDS = 1400;
    localparam int QUIET_TAIL = 120;
    localparam logic [POS_W-1:0] POS_MAX = '1;
    localparam logic [LEN_W-1:0] LEN_MAX = '1;
    localparam logic [TAG_W-1:0] TAG_MAX = '1;

    typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN} mix_t;

    typedef struct {
        logic             op;
        logic [TAG_W-1:0] tag;
        logic [POS_W-1:0] pos;
        logic [LEN_W-1:0] len;
        bit               settle;
        bit               steady;
    } request_word_t;

    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [TAG_W-1:0]    tag;
        logic [POS_W-1:0]    pos;
        logic [LEN_W-1:0]    len;
    } sched_result_t;

    logic clk = 1'b0;
    logic rst_n;

    nsrs_req_if req_ch();
    nsrs_rsp_if rsp_ch();

    nearest_seek_request_scheduler #(.QUEUE_DEPTH(DEPTH)) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    request_word_t backlog[$];
    sched_result_t awaited[$];

    bit               q_used[DEPTH];
    bit               q_low[DEPTH];
    logic [POS_W-1:0] q_pos[DEPTH];
    logic [LEN_W-1:0] q_len[DEPTH];
    logic [TAG_W-1:0] q_tag[DEPTH];
    logic [AGE_W-1:0] q_stamp[DEPTH];
    logic [AGE_W-1:0] stamp_ctr = '0;
    logic [POS_W-1:0] head_pos = '0;

    int mismatches = 0;
    int words_sent = 0;
    int words_checked = 0;
    int quiet_from = 0;
    int gap_left = 0;
    int stall_left = 0;
    int calm_left = 0;
    bit req_taken = 1'b0;

    initial
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            q_used[i] = 1'b0;
        end
    end

    // want_low picks the smaller sector, ties go to the longest waiting
    function automatic bit outranks(int a, int b, bit want_low);
        logic [AGE_W-1:0] wait_a;
        logic [AGE_W-1:0] wait_b;
        if (b < 0)
            return 1'b1;
        if (q_pos[a] != q_pos[b])
            return want_low ? (q_pos[a] < q_pos[b]) : (q_pos[a] > q_pos[b]);
        wait_a = stamp_ctr - q_stamp[a];
        wait_b = stamp_ctr - q_stamp[b];
        return wait_a > wait_b;
    endfunction

    function automatic sched_result_t seek_schedule(logic op, logic [TAG_W-1:0] tag,
                                                    logic [POS_W-1:0] pos,
                                                    logic [LEN_W-1:0] len);
        sched_result_t r;
        int free_slot;
        int hi;
        int lo;
        int pick;
        longint up;
        longint down;
        logic [POS_W:0] ending;
        r.status = nsrs_pkg::STATUS_INSERTED;
        r.tag = '0;
        r.pos = '0;
        r.len = '0;
        if (op == nsrs_pkg::OP_INSERT)
        begin
            free_slot = -1;
            for (int i = 0; i < DEPTH; i++)
            begin
                if (!q_used[i] && free_slot < 0)
                    free_slot = i;
            end
            if (free_slot < 0)
            begin
                r.status = nsrs_pkg::STATUS_FULL;
                return r;
            end
            q_used[free_slot] = 1'b1;
            q_low[free_slot] = (head_pos != '0) && (head_pos > pos);
            q_pos[free_slot] = pos;
            q_len[free_slot] = len;
            q_tag[free_slot] = tag;
            q_stamp[free_slot] = stamp_ctr;
            stamp_ctr = stamp_ctr + 1'b1;
            return r;
        end
        hi = -1;
        lo = -1;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (q_used[i])
            begin
                if (q_low[i])
                begin
                    if (outranks(i, lo, 1'b0))
                        lo = i;
                end
                else if (outranks(i, hi, 1'b1))
                    hi = i;
            end
        end
        if (hi < 0 && lo < 0)
        begin
            r.status = nsrs_pkg::STATUS_EMPTY;
            return r;
        end
        if (hi >= 0 && lo >= 0)
        begin
            up = longint'(q_pos[hi]) - longint'(head_pos);
            down = longint'(head_pos) - longint'(q_pos[lo]);
            pick = (up > down) ? lo : hi;
        end
        else
            pick = (hi >= 0) ? hi : lo;
        q_used[pick] = 1'b0;
        ending = {1'b0, q_pos[pick]} + q_len[pick];
        head_pos = ending[POS_W] ? POS_MAX : ending[POS_W-1:0];
        r.status = nsrs_pkg::STATUS_DISPATCHED;
        r.tag = q_tag[pick];
        r.pos = q_pos[pick];
        r.len = q_len[pick];
        return r;
    endfunction

    task automatic add_word(logic op, logic [TAG_W-1:0] tag, logic [POS_W-1:0] pos,
                            logic [LEN_W-1:0] len);
        request_word_t w;
        w.op = op;
        w.tag = tag;
        w.pos = pos;
        w.len = len;
        w.settle = 1'b0;
        w.steady = 1'b0;
        backlog.push_back(w);
    endtask

    // request side: accepted words update the predictor
    always @(posedge clk)
    begin
        if (rst_n && req_ch.valid && req_ch.ready)
        begin
            awaited.push_back(seek_schedule(req_ch.opcode, req_ch.request_tag,
                                            req_ch.request_position, req_ch.request_length));
            words_sent++;
            req_taken <= 1'b1;
        end
        else
            req_taken <= 1'b0;
    end

    always @(negedge clk)
    begin
        if (rst_n && !(req_ch.valid && !req_taken))
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                req_ch.valid <= 1'b0;
            end
            else if (backlog.size() == 0 || (backlog[0].settle && awaited.size() != 0))
                req_ch.valid <= 1'b0;
            else if (!backlog[0].steady && words_sent < quiet_from
                     && $urandom_range(0, 5) == 0)
            begin
                gap_left = $urandom_range(0, 4);
                req_ch.valid <= 1'b0;
            end
            else
            begin
                req_ch.opcode <= backlog[0].op;
                req_ch.request_tag <= backlog[0].tag;
                req_ch.request_position <= backlog[0].pos;
                req_ch.request_length <= backlog[0].len;
                req_ch.valid <= 1'b1;
                void'(backlog.pop_front());
            end
        end
    end

    // response side
    always @(posedge clk)
    begin : check_results
        sched_result_t due;
        string exp_s;
        string act_s;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            words_checked++;
            act_s = $sformatf("status %0d tag %h pos %h len %h", rsp_ch.status,
                              rsp_ch.out_tag, rsp_ch.out_position, rsp_ch.out_length);
            if (awaited.size() == 0)
            begin
                mismatches++;
                $display("%0t unexpected word: expected none, actual %s", $time, act_s);
            end
            else
            begin
                due = awaited.pop_front();
                if (due.status !== rsp_ch.status || due.tag !== rsp_ch.out_tag
                    || due.pos !== rsp_ch.out_position || due.len !== rsp_ch.out_length)
                begin
                    mismatches++;
                    exp_s = $sformatf("status %0d tag %h pos %h len %h", due.status,
                                      due.tag, due.pos, due.len);
                    $display("%0t mismatch: expected %s, actual %s", $time, exp_s, act_s);
                end
            end
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
            rsp_ch.ready <= 1'b0;
        else if (stall_left > 0)
        begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
        end
        else if (calm_left > 0 || words_checked >= quiet_from)
        begin
            if (calm_left > 0)
                calm_left--;
            rsp_ch.ready <= 1'b1;
        end
        else
        begin
            case ($urandom_range(0, 9))
                0, 1:
                begin
                    stall_left = $urandom_range(0, 4);
                    rsp_ch.ready <= 1'b0;
                end
                2:
                begin
                    calm_left = $urandom_range(20, 150);
                    rsp_ch.ready <= 1'b1;
                end
                default:
                    rsp_ch.ready <= 1'b1;
            endcase
        end
    end

    initial
    begin : stimulus
        request_word_t w;
        int seg_left;
        int ins_pct;
        mix_t mix;
        bit calm_seg;
        bit settle_next;
        rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.opcode = nsrs_pkg::OP_INSERT;
        req_ch.request_tag = '0;
        req_ch.request_position = '0;
        req_ch.request_length = '0;
        rsp_ch.ready = 1'b0;

        add_word(nsrs_pkg::OP_DISPATCH, '0, '0, '0);
        add_word(nsrs_pkg::OP_INSERT, '0, '0, '0);
        add_word(nsrs_pkg::OP_INSERT, TAG_MAX, POS_MAX, LEN_MAX);
        add_word(nsrs_pkg::OP_DISPATCH, '0, '0, '0);
        add_word(nsrs_pkg::OP_DISPATCH, '0, '0, '0);
        add_word(nsrs_pkg::OP_INSERT, 16'h000a, 48'd100, 16'd5);
        add_word(nsrs_pkg::OP_INSERT, 16'h000b, 48'd100, 16'd7);
        add_word(nsrs_pkg::OP_INSERT, 16'h000c, POS_MAX, '0);
        add_word(nsrs_pkg::OP_DISPATCH, '0, '0, '0);
        add_word(nsrs_pkg::OP_DISPATCH, '0, '0, '0);
        add_word(nsrs_pkg::OP_INSERT, 16'h000d, 48'd200, 16'd1);
        add_word(nsrs_pkg::OP_INSERT, 16'h000e, 48'd50, 16'd0);
        add_word(nsrs_pkg::OP_DISPATCH, '0, '0, '0);
        add_word(nsrs_pkg::OP_DISPATCH, '0, '0, '0);
        add_word(nsrs_pkg::OP_DISPATCH, '0, '0, '0);
        add_word(nsrs_pkg::OP_DISPATCH, '0, '0, '0);
        // equal up and down distance goes up
        add_word(nsrs_pkg::OP_INSERT, 16'h0011, 48'd301, 16'd0);
        add_word(nsrs_pkg::OP_INSERT, 16'h0012, 48'd101, 16'd0);
        add_word(nsrs_pkg::OP_DISPATCH, TAG_MAX, POS_MAX, LEN_MAX);
        add_word(nsrs_pkg::OP_DISPATCH, '0, '0, '0);

        seg_left = 0;
        settle_next = 1'b0;
        mix = MIX_EVEN;
        calm_seg = 1'b0;
        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            if (seg_left == 0)
            begin
                seg_left = $urandom_range(30, 120);
                mix = mix_t'($urandom_range(0, 2));
                calm_seg = ($urandom_range(0, 3) == 0);
                settle_next = (n == 0) || ($urandom_range(0, 3) == 0);
            end
            seg_left--;
            ins_pct = (mix == MIX_FILL) ? 85 : (mix == MIX_DRAIN) ? 25 : 50;
            w.op = ($urandom_range(1, 100) <= ins_pct) ? nsrs_pkg::OP_INSERT
                                                       : nsrs_pkg::OP_DISPATCH;
            w.tag = TAG_W'($urandom());
            case ($urandom_range(0, 9))
                0, 1, 2, 3: w.pos = POS_W'($urandom_range(0, 1023));
                4, 5:       w.pos = POS_MAX - $urandom_range(0, 1023);
                6:          w.pos = $urandom_range(0, 1) ? POS_MAX : '0;
                default:    w.pos = POS_W'({$urandom(), $urandom()});
            endcase
            case ($urandom_range(0, 9))
                0:       w.len = '0;
                1:       w.len = LEN_MAX;
                2, 3, 4: w.len = LEN_W'($urandom_range(0, 64));
                default: w.len = LEN_W'($urandom());
            endcase
            w.settle = settle_next;
            w.steady = calm_seg;
            settle_next = 1'b0;
            backlog.push_back(w);
        end
        quiet_from = backlog.size() - QUIET_TAIL;

        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        while (backlog.size() != 0 || req_ch.valid || awaited.size() != 0)
            @(negedge clk);
        repeat (DEPTH + 10) @(negedge clk);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
